@@ sv/ubs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubs_pkg
// Shared widths, constants and types of the block uniformity statistics
// block.
// ---------------------------------------------------------------------------
package ubs_pkg;

   localparam int LEN_W      = 16;
   localparam logic [LEN_W-1:0] LEN_RESET = 16'd1000;

   localparam int CNT_W      = 16;   // samples per block, bin counts, block index
   localparam int SUM_W      = 40;   // running sample sum
   localparam int DSUM_W     = 64;   // running sum of squared deviations
   localparam int SQ_W       = 33;   // sum of squared bin counts

   localparam int MUL_W      = 33;   // shared multiplier operand width
   localparam int PROD_W     = 2 * MUL_W;

   localparam int DIVIDEND_W = 64;
   localparam int DIVISOR_W  = 17;   // sample count of a block, up to 65536
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

   localparam int CHI_FRAC   = 8;

   localparam int MEAN_W     = 24;
   localparam int MSD_W      = 23;
   localparam int CHI_W      = 31;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ sv/ubs_mul.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubs_mul
// Shared unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
module ubs_mul (
   input  logic                        clock,
   input  logic [ubs_pkg::MUL_W-1:0]   op_a,
   input  logic [ubs_pkg::MUL_W-1:0]   op_b,
   output logic [ubs_pkg::PROD_W-1:0]  product
);

   logic [ubs_pkg::PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= ubs_pkg::PROD_W'(op_a) * ubs_pkg::PROD_W'(op_b);
   end

   assign product = product_ff;

endmodule

@@ sv/ubs_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubs_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ubs_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ubs_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [ubs_pkg::DIVISOR_W-1:0]   divisor,
   output logic [ubs_pkg::DIVIDEND_W-1:0]  quotient,
   output ubs_pkg::div_status_type         status
);

   localparam int DW = ubs_pkg::DIVIDEND_W;
   localparam int VW = ubs_pkg::DIVISOR_W;
   localparam int CW = ubs_pkg::DIV_CNT_W;

   logic [DW-1:0] quo_ff;
   logic [VW-1:0] rem_ff;
   logic [VW-1:0] den_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;

   logic [VW:0]   trial;
   logic [VW:0]   diff;
   logic          fits;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            den_ff  <= divisor;
            cnt_ff  <= CW'(DW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[DW-2:0], fits};
            rem_ff <= fits ? diff[VW-1:0] : trial[VW-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ sv/ubs_bins.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubs_bins
// Bin count memory with registered read, read-before-write, and per-entry
// valid bits so that reset leaves every bin at zero.
// ---------------------------------------------------------------------------
module ubs_bins #(
   parameter int BINS = 100
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [$clog2(BINS)-1:0]    rd_addr,
   output logic [ubs_pkg::CNT_W-1:0]  rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(BINS)-1:0]    wr_addr,
   input  logic [ubs_pkg::CNT_W-1:0]  wr_data
);

   logic [ubs_pkg::CNT_W-1:0] mem [BINS];
   logic [BINS-1:0]           valid_ff;
   logic [ubs_pkg::CNT_W-1:0] data_ff;
   logic                      rvalid_ff;

   always_ff @(posedge clock) begin
      data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // never-written entry reads as zero
   assign rd_data = rvalid_ff ? data_ff : '0;

endmodule

@@ sv/block_uniformity_statistics.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// block_uniformity_statistics
// Per-block mean, mean squared deviation from one half and chi-square of
// uniform samples, built around one shared multiplier and one divider.
// ---------------------------------------------------------------------------
// Each sample passes through accept, bin index multiply, deviation square
// multiply with bin read and bin write-back; a new sample is accepted only once
// the previous one has been written back. After the last sample of a block the
// block stays busy: it sweeps the bin memory (squares each count, clears it),
// scales the sum of squares, runs three divisions by the sample count to produce
// the mean, the mean squared deviation and the chi-square, and moves the result
// to the output register; that last step waits while the previous result has
// not been taken. The result waits in an output register; the next block's
// samples are accepted while it is pending. Bins start at zero after reset with
// no clearing pass.
// ---------------------------------------------------------------------------
module block_uniformity_statistics #(
   parameter int BINS        = 100,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [SAMPLE_BITS-1:0]        req_sample,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ubs_pkg::CNT_W-1:0]     rsp_block_number,
   output logic [ubs_pkg::MEAN_W-1:0]    rsp_block_mean,
   output logic [ubs_pkg::MSD_W-1:0]     rsp_mean_square_deviation,
   output logic [ubs_pkg::CHI_W-1:0]     rsp_chi_square,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ubs_pkg::LEN_W-1:0]     csr_block_length
);

   localparam int BIN_W = $clog2(BINS);
   localparam int IDX_W = $clog2(BINS + 1);
   localparam int MW    = ubs_pkg::MUL_W;
   localparam int PW    = ubs_pkg::PROD_W;
   localparam int SW    = ubs_pkg::SUM_W;
   localparam int DSW   = ubs_pkg::DSUM_W;
   localparam int QW    = ubs_pkg::SQ_W;
   localparam int DVW   = ubs_pkg::DIVIDEND_W;
   localparam int NW    = ubs_pkg::DIVISOR_W;
   localparam int CW    = ubs_pkg::CNT_W;
   localparam int CF    = ubs_pkg::CHI_FRAC;
   localparam logic [SAMPLE_BITS-1:0] HALF = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE, ST_BIN, ST_DEV, ST_INC, ST_SQ,
      ST_CHIM, ST_CHIW, ST_DIV, ST_DIVW, ST_PUT
   } state_type;

   typedef enum logic [1:0] {
      DIV_MEAN, DIV_MSD, DIV_CHI
   } div_sel_type;

   state_type                  state_ff, state_in;
   div_sel_type                sel_ff;

   logic [ubs_pkg::LEN_W-1:0]  len_ff;
   logic [SAMPLE_BITS-1:0]     s_ff;
   logic [BIN_W-1:0]           bin_ff;
   logic [SW-1:0]              sum_ff;
   logic [DSW-1:0]             dsum_ff;
   logic [CW-1:0]              seen_ff;
   logic [CW-1:0]              blocks_ff;
   logic [QW-1:0]              sq_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic                       p1_ff;
   logic                       p2_ff;
   logic [DVW-1:0]             chi_num_ff;
   logic [ubs_pkg::MEAN_W-1:0] mean_ff;
   logic [ubs_pkg::MSD_W-1:0]  msd_ff;
   logic [ubs_pkg::CHI_W-1:0]  chi_ff;

   logic                       rsp_valid_ff;
   logic [CW-1:0]              rsp_number_ff;
   logic [ubs_pkg::MEAN_W-1:0] rsp_mean_ff;
   logic [ubs_pkg::MSD_W-1:0]  rsp_msd_ff;
   logic [ubs_pkg::CHI_W-1:0]  rsp_chi_ff;

   logic [SAMPLE_BITS-1:0]     dev;
   logic [MW-1:0]              mul_a, mul_b;
   logic [PW-1:0]              prod;
   logic [BIN_W-1:0]           prod_bin;
   logic [BIN_W-1:0]           rd_addr, wr_addr;
   logic [CW-1:0]              rd_data, wr_data;
   logic                       wr_en;
   logic [CW-1:0]              seen_inc;
   logic [ubs_pkg::LEN_W-1:0]  len_eff;
   logic                       block_end;
   logic                       sweep_issue;
   logic                       sweep_done;
   logic [NW-1:0]              n;
   logic [NW+CF-1:0]           n_scaled;
   logic                       div_start;
   logic [DVW-1:0]             div_dividend;
   logic [DVW-1:0]             div_quo;
   logic [DVW-1:0]             quo_shift;
   logic [DVW-1:0]             chi_val;
   ubs_pkg::div_status_type    div_stat;
   logic                       put_go;

   assign dev        = (s_ff >= HALF) ? (s_ff - HALF) : (HALF - s_ff);
   assign prod_bin   = prod[SAMPLE_BITS +: BIN_W];
   assign seen_inc   = seen_ff + 1'b1;
   assign len_eff    = (len_ff == '0) ? ubs_pkg::LEN_W'(1) : len_ff;
   assign block_end  = (seen_inc == '0) || (seen_inc >= len_eff);
   assign sweep_issue = (state_ff == ST_SQ) && (idx_ff < IDX_W'(BINS));
   assign sweep_done = (idx_ff == IDX_W'(BINS)) && !p1_ff && !p2_ff;
   assign n          = (seen_ff == '0) ? {1'b1, {(NW-1){1'b0}}} : {1'b0, seen_ff};
   assign n_scaled   = {n, {CF{1'b0}}};
   assign div_start  = (state_ff == ST_DIV);
   assign quo_shift  = div_quo >> SAMPLE_BITS;
   assign chi_val    = (div_quo >= DVW'(n_scaled)) ? (div_quo - DVW'(n_scaled)) : '0;
   assign put_go     = (state_ff == ST_PUT) && (!rsp_valid_ff || rsp_ready);

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_BIN: begin
            mul_a = MW'(s_ff);
            mul_b = MW'(BINS);
         end
         ST_DEV: begin
            mul_a = MW'(dev);
            mul_b = MW'(dev);
         end
         ST_SQ: begin
            mul_a = MW'(rd_data);
            mul_b = MW'(rd_data);
         end
         ST_CHIM: begin
            mul_a = MW'(sq_ff);
            mul_b = MW'(BINS);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // bin memory port select
   always_comb begin
      rd_addr = (state_ff == ST_SQ) ? idx_ff[BIN_W-1:0] : prod_bin;
      wr_en   = 1'b0;
      wr_addr = bin_ff;
      wr_data = rd_data + 1'b1;
      if (state_ff == ST_INC) begin
         wr_en = 1'b1;
      end else if (sweep_issue) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff[BIN_W-1:0];
         wr_data = '0;
      end
   end

   always_comb begin
      case (sel_ff)
         DIV_MEAN: div_dividend = DVW'(sum_ff);
         DIV_MSD:  div_dividend = dsum_ff;
         DIV_CHI:  div_dividend = chi_num_ff;
         default:  div_dividend = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_BIN;
         ST_BIN:  state_in = ST_DEV;
         ST_DEV:  state_in = ST_INC;
         ST_INC:  state_in = block_end ? ST_SQ : ST_IDLE;
         ST_SQ:   if (sweep_done) state_in = ST_CHIM;
         ST_CHIM: state_in = ST_CHIW;
         ST_CHIW: state_in = ST_DIV;
         ST_DIV:  state_in = ST_DIVW;
         ST_DIVW: begin
            if (div_stat.done) begin
               state_in = (sel_ff == DIV_CHI) ? ST_PUT : ST_DIV;
            end
         end
         ST_PUT:  if (put_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= ubs_pkg::LEN_RESET;
         sum_ff       <= '0;
         dsum_ff      <= '0;
         seen_ff      <= '0;
         blocks_ff    <= '0;
         idx_ff       <= '0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         sel_ff       <= DIV_MEAN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            len_ff <= csr_block_length;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  s_ff <= req_sample;
               end
            end
            ST_BIN: begin
               sum_ff <= sum_ff + SW'(s_ff);
            end
            ST_DEV: begin
               bin_ff <= prod_bin;
            end
            ST_INC: begin
               dsum_ff <= dsum_ff + prod[DSW-1:0];
               seen_ff <= seen_inc;
               idx_ff  <= '0;
               p1_ff   <= 1'b0;
               p2_ff   <= 1'b0;
               sq_ff   <= '0;
            end
            ST_SQ: begin
               // read, square and clear one bin per cycle
               if (sweep_issue) begin
                  idx_ff <= idx_ff + 1'b1;
               end
               p1_ff <= sweep_issue;
               p2_ff <= p1_ff;
               if (p2_ff) begin
                  sq_ff <= sq_ff + prod[QW-1:0];
               end
            end
            ST_CHIW: begin
               chi_num_ff <= {prod[DVW-CF-1:0], {CF{1'b0}}};
               sel_ff     <= DIV_MEAN;
            end
            ST_DIVW: begin
               if (div_stat.done) begin
                  case (sel_ff)
                     DIV_MEAN: begin
                        mean_ff <= div_quo[ubs_pkg::MEAN_W-1:0];
                        sel_ff  <= DIV_MSD;
                     end
                     DIV_MSD: begin
                        msd_ff <= quo_shift[ubs_pkg::MSD_W-1:0];
                        sel_ff <= DIV_CHI;
                     end
                     default: begin
                        chi_ff <= chi_val[ubs_pkg::CHI_W-1:0];
                     end
                  endcase
               end
            end
            ST_PUT: begin
               if (put_go) begin
                  rsp_number_ff <= blocks_ff;
                  rsp_mean_ff   <= mean_ff;
                  rsp_msd_ff    <= msd_ff;
                  rsp_chi_ff    <= chi_ff;
                  blocks_ff     <= blocks_ff + 1'b1;
                  sum_ff        <= '0;
                  dsum_ff       <= '0;
                  seen_ff       <= '0;
               end
            end
            default: begin
            end
         endcase
         if (put_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   ubs_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   ubs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (n),
      .quotient (div_quo),
      .status   (div_stat)
   );

   ubs_bins #(
      .BINS (BINS)
   ) u_bins (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_ready                 = (state_ff == ST_IDLE);
   assign csr_ready                 = 1'b1;
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_block_number          = rsp_number_ff;
   assign rsp_block_mean            = rsp_mean_ff;
   assign rsp_mean_square_deviation = rsp_msd_ff;
   assign rsp_chi_square            = rsp_chi_ff;

   a_one_item_at_a_time : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new item accepted while the previous one is in work");

   a_div_start_idle : assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_bin_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INC) |-> (32'(bin_ff) < BINS))
      else $error("bin index out of range");

   a_result_from_put : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PUT))
      else $error("result raised outside the hand-off state");

endmodule
